FILE: src/seven_segment_number_formatter_core_assert.svh
// Assertion macros for the seven-segment number formatter.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_CORE_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset
`define SSNF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen outside reset
`define SSNF_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SSNF_ASSERT(label, prop, msg)
`define SSNF_NEVER(label, cond, msg)
`endif

`endif

FILE: src/ssnf_pkg.sv
// Shared types, constants and the digit pattern table for the formatter.
// No dependencies; imported by the interfaces, the RTL modules and the bench.
`timescale 1ns / 1ps
`default_nettype none

package ssnf_pkg;

    localparam int VALUE_W = 24;
    localparam int SEG_W   = 8;
    localparam int DIGITS  = 4;
    localparam int NUM_W   = 14;   // largest shown number is 9999
    localparam int DOT_POS = 2;    // units digit in decimal mode

    localparam logic [SEG_W-1:0] SEG_OFF   = 8'h00;
    localparam logic [SEG_W-1:0] SEG_DOT   = 8'h80;
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;

    typedef logic [DIGITS-1:0][SEG_W-1:0] seg_row_t;

    // Number to show plus how to show it
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             neg;
        logic             dec;
        logic             ovf;
    } prep_t;

    // Segment pattern of one decimal digit
    function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = SEG_OFF;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: src/ssnf_if.sv
// Valid/ready channel interfaces for the formatter input and result items.
// Depends on ssnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ssnf_in_if
    import ssnf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value_tenths;

    modport source (output valid, output value_tenths, input ready);
    modport sink   (input valid, input value_tenths, output ready);
endinterface

interface ssnf_out_if
    import ssnf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] digit0_segments;
    logic [SEG_W-1:0] digit1_segments;
    logic [SEG_W-1:0] digit2_segments;
    logic [SEG_W-1:0] digit3_segments;

    modport source (output valid, output digit0_segments, output digit1_segments,
                    output digit2_segments, output digit3_segments, input ready);
    modport sink   (input valid, input digit0_segments, input digit1_segments,
                    input digit2_segments, input digit3_segments, output ready);
endinterface

`default_nettype wire

FILE: src/ssnf_prep.sv
// Magnitude, mode choice and round-half-even division by ten.
// Depends on ssnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssnf_prep
    import ssnf_pkg::*;
(
    input  wire logic signed [VALUE_W-1:0] value,
    output prep_t                          item
);

    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic               dec;
    logic               big;
    logic [16:0]        m17;
    logic [32:0]        prod;
    logic [NUM_W-1:0]   quo;
    logic [16:0]        quo10;
    logic [16:0]        diff;
    logic [3:0]         rem;
    logic               up;
    logic [NUM_W-1:0]   qr;

    // Take the magnitude of the two's complement value
    assign raw = value;
    assign neg = raw[VALUE_W-1];
    assign mag = neg ? (~raw + 24'd1) : raw;

    // Decimal mode window
    assign dec = neg ? (mag <= 24'd999) : (mag <= 24'd9999);

    // At or above 100000 the rounded number can never fit
    assign big = (mag >= 24'd100000);

    // Divide by ten through the reciprocal, exact below 262139
    assign m17   = mag[16:0];
    assign prod  = {16'd0, m17} * 33'd52429;
    assign quo   = prod[32:19];
    assign quo10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
    assign diff  = m17 - quo10;
    assign rem   = diff[3:0];

    // Round the tenths away, ties to even
    assign up = (rem > 4'd5) || ((rem == 4'd5) && quo[0]);
    assign qr = quo + {{(NUM_W-1){1'b0}}, up};

    always_comb
    begin
        item.neg = neg;
        item.dec = dec;
        item.num = dec ? mag[NUM_W-1:0] : qr;
        item.ovf = !dec && (big || (neg ? (qr > 14'd999) : (qr > 14'd9999)));
    end

endmodule

`default_nettype wire

FILE: src/ssnf_render.sv
// Digit split and right-aligned pattern placement for four positions.
// Depends on ssnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssnf_render
    import ssnf_pkg::*;
(
    input  prep_t    item,
    output seg_row_t seg
);

    logic [27:0]      p1000;
    logic [26:0]      p100;
    logic [29:0]      p10;
    logic [4:0]       thou;
    logic [7:0]       hund;
    logic [10:0]      tens;
    logic [NUM_W-1:0] tens10;
    logic [10:0]      hund10;
    logic [7:0]       thou10;
    logic [NUM_W-1:0] d_units;
    logic [10:0]      d_tens;
    logic [7:0]       d_hund;
    logic [3:0]       dig [DIGITS];
    logic [2:0]       sig;
    logic [2:0]       ndig;
    logic [2:0]       rank;

    // Quotients by 1000, 100 and 10 in parallel through reciprocals
    assign p1000 = {14'd0, item.num} * 28'd8389;
    assign p100  = {13'd0, item.num} * 27'd5243;
    assign p10   = {16'd0, item.num} * 30'd52429;
    assign thou  = p1000[27:23];
    assign hund  = p100[26:19];
    assign tens  = p10[29:19];

    // Digits as differences of neighbouring quotients
    assign tens10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
    assign hund10  = {hund, 3'b000} + {2'b00, hund, 1'b0};
    assign thou10  = {thou, 3'b000} + {2'b00, thou, 1'b0};
    assign d_units = item.num - tens10;
    assign d_tens  = tens - hund10;
    assign d_hund  = hund - thou10;

    always_comb
    begin
        dig[0] = d_units[3:0];
        dig[1] = d_tens[3:0];
        dig[2] = d_hund[3:0];
        dig[3] = thou[3:0];
    end

    // Count significant digits, at least two in decimal mode
    always_comb
    begin
        priority if (item.num >= 14'd1000)
            sig = 3'd4;
        else if (item.num >= 14'd100)
            sig = 3'd3;
        else if (item.num >= 14'd10)
            sig = 3'd2;
        else
            sig = 3'd1;
        ndig = (item.dec && sig < 3'd2) ? 3'd2 : sig;
    end

    // Place digits from the right, then the sign, then blanks; all minus on overflow
    always_comb
    begin
        rank = 3'd0;
        for (int p = 0; p < DIGITS; p++)
        begin
            rank = 3'(DIGITS - 1 - p);
            if (item.ovf)
                seg[p] = SEG_MINUS;
            else if (rank < ndig)
                seg[p] = digit_seg(dig[rank[1:0]]);
            else if (rank == ndig && item.neg)
                seg[p] = SEG_MINUS;
            else
                seg[p] = SEG_OFF;
            if (!item.ovf && item.dec && p == DOT_POS)
                seg[p] = seg[p] | SEG_DOT;
        end
    end

endmodule

`default_nettype wire

FILE: src/seven_segment_number_formatter_core.sv
// Top level: three-register pipeline around the prep and render logic.
// Depends on ssnf_pkg, ssnf_if, ssnf_prep, ssnf_render and the assert header.
//
//  channel  direction  payload
//  -------  ---------  -----------------------------------------------
//  din      sink       value_tenths, signed 24-bit tenths
//  dout     source     digit0..digit3_segments, 8 bits each, left first
//
// One item per cycle while dout is ready; an accepted item passes through the
// input register, prep register and result register in turn to reach dout.
// Each stage takes a new item when empty or when it hands its own on, so a
// stall at dout holds the items in place and ripples back to din.ready.
// Reset clears the three valid flags only.
`timescale 1ns / 1ps
`default_nettype none

`include "seven_segment_number_formatter_core_assert.svh"

module seven_segment_number_formatter_core
    import ssnf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ssnf_in_if.sink    din,
    ssnf_out_if.source dout
);

    logic                      v0_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic signed [VALUE_W-1:0] val_reg;
    prep_t                     prep_reg;
    seg_row_t                  seg_reg;
    prep_t                     prep_next;
    seg_row_t                  seg_next;
    logic                      s2_ready;
    logic                      s1_ready;
    logic                      s0_ready;

    // Stage readiness, from the output back
    assign s2_ready = !v2_reg || dout.ready;
    assign s1_ready = !v1_reg || s2_ready;
    assign s0_ready = !v0_reg || s1_ready;

    assign din.ready = s0_ready;

    ssnf_prep u_prep
    (
        .value (val_reg),
        .item  (prep_next)
    );

    ssnf_render u_render
    (
        .item (prep_reg),
        .seg  (seg_next)
    );

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
                v0_reg <= din.valid;
            if (s1_ready)
                v1_reg <= v0_reg;
            if (s2_ready)
                v2_reg <= v1_reg;
        end
    end

    // Hold or advance the payload of each stage
    always_ff @(posedge clk)
    begin
        if (s0_ready && din.valid)
            val_reg <= din.value_tenths;
        if (s1_ready && v0_reg)
            prep_reg <= prep_next;
        if (s2_ready && v1_reg)
            seg_reg <= seg_next;
    end

    assign dout.valid           = v2_reg;
    assign dout.digit0_segments = seg_reg[0];
    assign dout.digit1_segments = seg_reg[1];
    assign dout.digit2_segments = seg_reg[2];
    assign dout.digit3_segments = seg_reg[3];

    // An accepted item lands in the input register
    `SSNF_ASSERT(a_in_capture, (din.valid && din.ready) |=> v0_reg, "accepted item lost at input stage")
    // A prepared item moving on lands in the result register
    `SSNF_ASSERT(a_mid_advance, (v1_reg && s2_ready) |=> v2_reg, "prepared item lost before result stage")
    // The point is only ever lit on the units position
    `SSNF_NEVER(a_dot_place, dout.valid && (dout.digit0_segments[7] || dout.digit1_segments[7] || dout.digit3_segments[7]), "decimal point on wrong position")
    // The rightmost position always shows something
    `SSNF_NEVER(a_right_lit, dout.valid && (dout.digit3_segments == SEG_OFF), "rightmost position blank")

endmodule

`default_nettype wire

FILE: bench/seven_segment_number_formatter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for seven_segment_number_formatter_core: a scoreboard
// predicts the four segment patterns of every accepted value and checks each
// result in order. Depends on ssnf_pkg, ssnf_if and the core RTL.

module seven_segment_number_formatter_core_tb
    import ssnf_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 700;
    localparam int TAIL_ITEMS    = 120;
    localparam int HOLD_ITEMS    = 30;
    localparam int LONG_HOLD     = 200;
    localparam int DRAIN_CYCLES  = 10;

    // Predicts display patterns and holds those still to come out
    class display_scoreboard;
        seg_row_t pending_rows[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function logic [SEG_W-1:0] glyph(int d);
            logic [SEG_W-1:0] g;
            case (d)
                0:       g = 8'h3F;
                1:       g = 8'h06;
                2:       g = 8'h5B;
                3:       g = 8'h4F;
                4:       g = 8'h66;
                5:       g = 8'h6D;
                6:       g = 8'h7D;
                7:       g = 8'h07;
                8:       g = 8'h7F;
                default: g = 8'h6F;
            endcase
            return g;
        endfunction

        // Right-align the digits, then one minus if negative, then blanks
        static function seg_row_t place_digits(int num, bit neg, int min_digits);
            seg_row_t row;
            int       n;
            int       count;
            bit       sign_done;
            n         = num;
            count     = 0;
            sign_done = !neg;
            for (int pos = DIGITS - 1; pos >= 0; pos--)
            begin
                if (count < min_digits || n != 0)
                begin
                    row[pos] = glyph(n % 10);
                    n        = n / 10;
                    count++;
                end
                else if (!sign_done)
                begin
                    row[pos]  = SEG_MINUS;
                    sign_done = 1'b1;
                end
                else
                begin
                    row[pos] = SEG_OFF;
                end
            end
            return row;
        endfunction

        static function seg_row_t format_value(logic signed [VALUE_W-1:0] value);
            seg_row_t row;
            int       v;
            int       mag;
            int       whole;
            int       frac;
            bit       neg;
            v   = value;
            neg = (v < 0);
            mag = neg ? -v : v;
            if (neg ? (mag <= 999) : (mag <= 9999))
            begin
                // One decimal: dot on the units digit
                row          = place_digits(mag, neg, 2);
                row[DOT_POS] = row[DOT_POS] | SEG_DOT;
            end
            else
            begin
                // Drop the decimal, ties to even; all minus if it does not fit
                whole = mag / 10;
                frac  = mag % 10;
                if (frac > 5 || (frac == 5 && (whole % 2) == 1))
                    whole++;
                if (neg ? (whole <= 999) : (whole <= 9999))
                    row = place_digits(whole, neg, 1);
                else
                    for (int k = 0; k < DIGITS; k++)
                        row[k] = SEG_MINUS;
            end
            return row;
        endfunction

        function void note_value(logic signed [VALUE_W-1:0] value);
            pending_rows.push_back(format_value(value));
        endfunction

        function void check_row(seg_row_t got);
            seg_row_t want;
            if (pending_rows.size() == 0)
            begin
                $error("result item with nothing pending: %h", got);
                mismatches++;
                return;
            end
            want = pending_rows.pop_front();
            for (int k = 0; k < DIGITS; k++)
            begin
                if (got[k] !== want[k])
                begin
                    $error("digit%0d_segments: expected %h, actual %h", k, want[k], got[k]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    bit   quiet_tail;
    bit   long_hold_req;
    int   hold_left;

    display_scoreboard board;

    ssnf_in_if  din_if ();
    ssnf_out_if dout_if ();

    seven_segment_number_formatter_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    // Clock, 20 ns period
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort on a run that never finishes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Note accepted items and check results; signals are stable at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && din_if.valid && din_if.ready)
            board.note_value(din_if.value_tenths);
        if (rst_n && dout_if.valid && dout_if.ready)
            board.check_row({dout_if.digit3_segments, dout_if.digit2_segments,
                             dout_if.digit1_segments, dout_if.digit0_segments});
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin
        dout_if.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                dout_if.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                dout_if.ready <= 1'b0;
            end
            else if (!quiet_tail && rst_n && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(1, 12) - 1;
                dout_if.ready <= 1'b0;
            end
            else
            begin
                dout_if.ready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until accepted; call at a rising edge
    task automatic offer_value(input logic signed [VALUE_W-1:0] value, input bit may_idle);
        int gap;
        if (may_idle && !quiet_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid        <= 1'b1;
        din_if.value_tenths <= value;
        @(negedge clk);
        while (!din_if.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Drop valid and wait for every pending result
    task automatic drain_results();
        din_if.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_rows.size() != 0)
            @(posedge clk);
    endtask

    // Random value aimed at the interesting regions
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int v;
        int boundary [12] = '{0, -9, -10, 999, -999, 9999, 10000, -1000,
                              99994, 99995, -9994, -9995};
        case ($urandom_range(0, 5))
            0: v = int'($urandom_range(0, 10998)) - 999;
            1: v = boundary[$urandom_range(0, 11)] + int'($urandom_range(0, 12)) - 6;
            2: v = int'($urandom_range(10000, 100004));
            3: v = -int'($urandom_range(1000, 10004));
            4: v = int'($urandom());
            default:
            begin
                v = 10 * int'($urandom_range(100, 10000)) + 5;
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v[VALUE_W-1:0];
    endfunction

    // Main sequence
    initial
    begin
        int directed [26];
        directed = '{0, 1, -1, -5, -9, -10, 99, 999, -999, -1000,
                     9999, 10000, 10004, 10005, 10015, 99985, 99994,
                     99995, -9985, -9994, -9995, -10005, 8388607,
                     -8388608, 123, -55};
        board         = new();
        cycle_count   = 0;
        quiet_tail    = 1'b0;
        long_hold_req = 1'b0;
        rst_n               <= 1'b0;
        din_if.valid        <= 1'b0;
        din_if.value_tenths <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed values: boundaries, ties, extremes
        foreach (directed[i])
            offer_value(directed[i][VALUE_W-1:0], 1'b1);

        // Pause the sender until everything is out
        drain_results();

        // Long receiver hold while the sender keeps offering
        long_hold_req = 1'b1;
        for (int i = 0; i < HOLD_ITEMS; i++)
            offer_value(pick_value(), 1'b0);

        // Random values with idling on both sides
        for (int i = 0; i < RANDOM_ITEMS; i++)
            offer_value(pick_value(), 1'b1);

        // Full rate to the end
        quiet_tail = 1'b1;
        for (int i = 0; i < TAIL_ITEMS; i++)
            offer_value(pick_value(), 1'b0);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.pending_rows.size() != 0)
        begin
            $error("%0d result items never arrived", board.pending_rows.size());
            board.mismatches++;
        end
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/ssnf_pkg.sv
src/ssnf_if.sv
src/ssnf_prep.sv
src/ssnf_render.sv
src/seven_segment_number_formatter_core.sv
bench/seven_segment_number_formatter_core_tb.sv
